[rtl/fss_pkg.sv]
// Package for the fair share task scheduler: beat types, codes, sizes and the weight table.
// Used by fss_ctrl, fss_datapath and fair_share_task_scheduler_core; depends on nothing.
package fss_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int RUN_SLOTS  = 16;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int RQ_W       = $clog2(RUN_SLOTS);
  localparam int WEIGHT_W   = 22;
  localparam int DIV_CNT_W  = 6;

  localparam logic [1:0] OP_NEW    = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_PICK   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_TABLE_FULL = 3'd1;
  localparam logic [2:0] STS_NO_TASK    = 3'd2;
  localparam logic [2:0] STS_RQ_FULL    = 3'd3;
  localparam logic [2:0] STS_RQ_EMPTY   = 3'd4;

  localparam logic REG_BASE_WEIGHT = 1'b0;
  localparam logic REG_EXIT_MASK   = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] proc_id;
    logic [5:0]  task_priority;
    logic [7:0]  proc_state;
    logic        set_priority;
    logic        set_state;
    logic [63:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] next_pid;
    logic [3:0]  task_slot;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_APPLY,
    S_ELAPSED,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV,
    S_CHARGE,
    S_SCAN,
    S_PICK
  } state_t;

  typedef struct packed {
    logic load;
    logic find;
    logic apply;
    logic elapsed;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic charge;
    logic scan_step;
    logic pick;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       div_last;
    logic       scan_last;
  } dp_status_t;

  function automatic logic [WEIGHT_W-1:0] prio_weight(input logic [5:0] prio);
    logic [WEIGHT_W-1:0] w;
    case (prio)
      6'd0:  w = 22'd378;
      6'd1:  w = 22'd472;
      6'd2:  w = 22'd590;
      6'd3:  w = 22'd737;
      6'd4:  w = 22'd922;
      6'd5:  w = 22'd1153;
      6'd6:  w = 22'd1441;
      6'd7:  w = 22'd1801;
      6'd8:  w = 22'd2252;
      6'd9:  w = 22'd2815;
      6'd10: w = 22'd3518;
      6'd11: w = 22'd4398;
      6'd12: w = 22'd5498;
      6'd13: w = 22'd6872;
      6'd14: w = 22'd8590;
      6'd15: w = 22'd10737;
      6'd16: w = 22'd13422;
      6'd17: w = 22'd16777;
      6'd18: w = 22'd20972;
      6'd19: w = 22'd26214;
      6'd20: w = 22'd32768;
      6'd21: w = 22'd40960;
      6'd22: w = 22'd51200;
      6'd23: w = 22'd64000;
      6'd24: w = 22'd80000;
      6'd25: w = 22'd100000;
      6'd26: w = 22'd125000;
      6'd27: w = 22'd156250;
      6'd28: w = 22'd195313;
      6'd29: w = 22'd244141;
      6'd30: w = 22'd305176;
      6'd31: w = 22'd381470;
      6'd32: w = 22'd476837;
      6'd33: w = 22'd596046;
      6'd34: w = 22'd745058;
      6'd35: w = 22'd931323;
      6'd36: w = 22'd1164150;
      6'd37: w = 22'd1455190;
      6'd38: w = 22'd1818990;
      default: w = 22'd2273740;
    endcase
    return w;
  endfunction

endpackage

[rtl/fss_ctrl.sv]
// Controller state machine of the fair share task scheduler.
// Depends on fss_pkg; drives the command struct of fss_datapath.
module fss_ctrl
  import fss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t dp_status,
  output dp_cmd_t    dp_cmd,
  output logic       busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dp_cmd    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          dp_cmd.load = 1'b1;
          state_nxt   = S_FIND;
        end
      end
      S_FIND: begin
        dp_cmd.find = 1'b1;
        state_nxt   = (dp_status.op == OP_PICK) ? S_ELAPSED : S_APPLY;
      end
      S_APPLY: begin
        dp_cmd.apply = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_ELAPSED: begin
        dp_cmd.elapsed = 1'b1;
        state_nxt      = S_MUL_LO;
      end
      S_MUL_LO: begin
        dp_cmd.mul_lo = 1'b1;
        state_nxt     = S_MUL_HI;
      end
      S_MUL_HI: begin
        dp_cmd.mul_hi = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        dp_cmd.div_step = 1'b1;
        if (dp_status.div_last) begin
          state_nxt = S_CHARGE;
        end
      end
      S_CHARGE: begin
        dp_cmd.charge = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        dp_cmd.scan_step = 1'b1;
        if (dp_status.scan_last) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        dp_cmd.pick = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

[rtl/fss_datapath.sv]
// Datapath of the fair share task scheduler: task table, run queue, multiplier and divider.
// Depends on fss_pkg; sequenced by fss_ctrl through dp_cmd_t and dp_status_t.
module fss_datapath
  import fss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     dp_cmd,
  output dp_status_t  dp_status,
  input  in_item_t    in_data,
  input  logic [15:0] base_weight,
  input  logic [7:0]  exit_mask,
  output logic        out_valid,
  output out_item_t   out_data
);

  logic [15:0]         pid_mem   [TASK_SLOTS];
  logic [5:0]          prio_mem  [TASK_SLOTS];
  logic [7:0]          state_mem [TASK_SLOTS];
  logic [63:0]         vr_r      [TASK_SLOTS];
  logic [63:0]         rt_r      [TASK_SLOTS];
  logic [63:0]         start_r   [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] active_r;
  logic [TASK_SLOTS-1:0] running_r;
  logic [RUN_SLOTS-1:0]  rq_valid_r;
  logic [SLOT_W-1:0]     rq_entry_r [RUN_SLOTS];
  logic [SLOT_W-1:0]     cur_r;

  in_item_t            item_r;
  logic                found_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [63:0]         elapsed_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [63:0]         acc_r;
  logic [WEIGHT_W-1:0] rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [RQ_W-1:0]     scan_idx_r;
  logic                best_found_r;
  logic [SLOT_W-1:0]   best_r;
  logic [63:0]         best_vr_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [TASK_SLOTS-1:0] match_vec;
  logic                  match_any;
  logic [SLOT_W-1:0]     match_idx;
  logic [RUN_SLOTS-1:0]  rq_present;
  logic [RUN_SLOTS-1:0]  rq_free;
  logic [RQ_W-1:0]       present_idx;
  logic [RQ_W-1:0]       free_idx;
  logic                  old_blocked;
  logic [7:0]            new_state;
  logic                  new_active;
  logic                  do_add;
  logic                  do_remove;
  logic [SLOT_W-1:0]     rd_addr;
  logic [63:0]           vr_rd;
  logic [SLOT_W-1:0]     scan_entry;
  logic [47:0]           mul_prod;
  logic [WEIGHT_W:0]     rem_sh;
  logic                  div_ge;

  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (item_r.opcode == OP_NEW) begin
        match_vec[i] = !active_r[i];
      end else begin
        match_vec[i] = active_r[i] && (pid_mem[i] == item_r.proc_id);
      end
    end
    match_any = |match_vec;
    match_idx = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        match_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < RUN_SLOTS; i++) begin
      rq_present[i] = rq_valid_r[i] && (rq_entry_r[i] == slot_r);
      rq_free[i]    = !rq_valid_r[i];
    end
    present_idx = '0;
    free_idx    = '0;
    for (int i = RUN_SLOTS - 1; i >= 0; i--) begin
      if (rq_present[i]) begin
        present_idx = RQ_W'(i);
      end
      if (rq_free[i]) begin
        free_idx = RQ_W'(i);
      end
    end
  end

  always_comb begin
    if (item_r.opcode == OP_NEW) begin
      old_blocked = 1'b1;
      new_state   = item_r.proc_state;
      new_active  = 1'b1;
    end else begin
      old_blocked = (state_mem[slot_r] != 8'd0);
      new_state   = item_r.set_state ? item_r.proc_state : state_mem[slot_r];
      new_active  = !(item_r.set_state && ((item_r.proc_state & exit_mask) != 8'd0));
    end
    do_add    = old_blocked && (new_state == 8'd0) && new_active;
    do_remove = !do_add && ((!old_blocked && (new_state != 8'd0)) || !new_active);
  end

  assign scan_entry = rq_entry_r[scan_idx_r];
  assign rd_addr    = dp_cmd.charge ? cur_r : scan_entry;
  assign vr_rd      = vr_r[rd_addr];
  assign mul_prod   = (dp_cmd.mul_lo ? acc_r[31:0] : acc_r[63:32]) * base_weight;
  assign rem_sh     = {rem_r, acc_r[63]};
  assign div_ge     = (rem_sh >= {1'b0, weight_r});

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      item_r <= in_data;
    end
    if (dp_cmd.find) begin
      found_r <= match_any;
      slot_r  <= match_idx;
    end
    if (dp_cmd.apply && found_r && (item_r.opcode == OP_NEW)) begin
      pid_mem[slot_r]   <= item_r.proc_id;
      prio_mem[slot_r]  <= item_r.task_priority;
      state_mem[slot_r] <= item_r.proc_state;
    end
    if (dp_cmd.apply && found_r && (item_r.opcode == OP_UPDATE)) begin
      if (item_r.set_priority) begin
        prio_mem[slot_r] <= item_r.task_priority;
      end
      if (item_r.set_state) begin
        state_mem[slot_r] <= item_r.proc_state;
      end
    end
    if (dp_cmd.elapsed) begin
      elapsed_r <= item_r.now_time - start_r[cur_r];
      acc_r     <= item_r.now_time - start_r[cur_r];
      weight_r  <= prio_weight(prio_mem[cur_r]);
    end
    if (dp_cmd.mul_lo) begin
      acc_r <= {elapsed_r[63:32], mul_prod[31:0]};
      rem_r <= {6'd0, mul_prod[47:32]};
    end
    if (dp_cmd.mul_hi) begin
      acc_r     <= {mul_prod[31:0] + {16'd0, rem_r[15:0]}, acc_r[31:0]};
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (dp_cmd.div_step) begin
      acc_r     <= {acc_r[62:0], div_ge};
      rem_r     <= div_ge ? WEIGHT_W'(rem_sh - {1'b0, weight_r}) : rem_sh[WEIGHT_W-1:0];
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (dp_cmd.charge) begin
      scan_idx_r   <= '0;
      best_found_r <= 1'b0;
    end
    if (dp_cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      if (rq_valid_r[scan_idx_r] && (!best_found_r || (vr_rd < best_vr_r))) begin
        best_found_r <= 1'b1;
        best_r       <= scan_entry;
        best_vr_r    <= vr_rd;
      end
    end
    if (dp_cmd.apply) begin
      out_data_r.next_pid <= '0;
      if (!found_r || (item_r.opcode != OP_NEW && item_r.opcode != OP_UPDATE)) begin
        out_data_r.task_slot <= '0;
        if (item_r.opcode == OP_NEW) begin
          out_data_r.status <= STS_TABLE_FULL;
        end else if (item_r.opcode == OP_UPDATE) begin
          out_data_r.status <= STS_NO_TASK;
        end else begin
          out_data_r.status <= STS_OK;
        end
      end else begin
        out_data_r.task_slot <= 4'(slot_r);
        out_data_r.status    <= (do_add && !(|rq_present) && !(|rq_free)) ?
                                STS_RQ_FULL : STS_OK;
      end
    end
    if (dp_cmd.pick) begin
      if (best_found_r) begin
        out_data_r.status    <= STS_OK;
        out_data_r.next_pid  <= pid_mem[best_r];
        out_data_r.task_slot <= 4'(best_r);
      end else begin
        out_data_r.status    <= STS_RQ_EMPTY;
        out_data_r.next_pid  <= '0;
        out_data_r.task_slot <= 4'(cur_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      running_r   <= '0;
      rq_valid_r  <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        vr_r[i]    <= '0;
        rt_r[i]    <= '0;
        start_r[i] <= '0;
      end
      for (int i = 0; i < RUN_SLOTS; i++) begin
        rq_entry_r[i] <= '0;
      end
    end else begin
      out_valid_r <= dp_cmd.apply || dp_cmd.pick;
      if (dp_cmd.apply && found_r &&
          (item_r.opcode == OP_NEW || item_r.opcode == OP_UPDATE)) begin
        active_r[slot_r] <= new_active;
        if (item_r.opcode == OP_NEW) begin
          vr_r[slot_r]      <= '0;
          rt_r[slot_r]      <= '0;
          running_r[slot_r] <= 1'b0;
        end
        if (do_add && !(|rq_present) && (|rq_free)) begin
          rq_valid_r[free_idx] <= 1'b1;
          rq_entry_r[free_idx] <= slot_r;
        end
        if (do_remove && (|rq_present)) begin
          rq_valid_r[present_idx] <= 1'b0;
        end
      end
      if (dp_cmd.charge) begin
        vr_r[cur_r] <= vr_rd + acc_r;
        rt_r[cur_r] <= rt_r[cur_r] + elapsed_r;
      end
      if (dp_cmd.pick && best_found_r) begin
        if (cur_r != best_r) begin
          running_r[cur_r] <= 1'b0;
        end
        running_r[best_r] <= 1'b1;
        start_r[best_r]   <= item_r.now_time;
        cur_r             <= best_r;
      end
    end
  end

  assign dp_status.op        = item_r.opcode;
  assign dp_status.div_last  = (div_cnt_r == {DIV_CNT_W{1'b1}});
  assign dp_status.scan_last = (scan_idx_r == RQ_W'(RUN_SLOTS - 1));
  assign out_valid           = out_valid_r;
  assign out_data            = out_data_r;

endmodule

[rtl/fair_share_task_scheduler_core.sv]
// Top level of the fair share task scheduler: configuration registers, controller, datapath.
// Depends on fss_pkg, fss_ctrl and fss_datapath.
//
// A command beat on in_data is taken at a clock edge with start high and busy low.
// New task and update commands, and the unused opcode, give their result beat on
// out_data after the find and apply states, marked by out_valid for one cycle.
// A pick charges the elapsed time to the current task through a 32x16 multiply
// in low and high halves and a one-bit-per-cycle 64-bit divide, then walks
// the run queue one entry per cycle to find the lowest virtual runtime.
// busy stays high until the result beat is loaded, so a new command can be taken
// in the cycle that the result is shown.
// The result beat cannot be held off by the receiver.
// Configuration: base_weight at byte address 0, exit_mask at byte address 4,
// written through the APB-style port; the user must write them only while the block
// is idle, and the block itself does not enforce this; pready is always high.
// Reset (rst_n low, synchronous) empties the task table and the run queue, clears
// runtimes and start times, selects slot 0 as current and restores the register defaults.
module fair_share_task_scheduler_core
  import fss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] base_weight_r;
  logic [7:0]  exit_mask_r;
  logic        cfg_wr;
  dp_cmd_t     dp_cmd;
  dp_status_t  dp_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_weight_r <= 16'd32768;
      exit_mask_r   <= 8'd128;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BASE_WEIGHT: base_weight_r <= pwdata[15:0];
        REG_EXIT_MASK:   exit_mask_r   <= pwdata[7:0];
        default:         base_weight_r <= base_weight_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BASE_WEIGHT: prdata = {16'd0, base_weight_r};
      REG_EXIT_MASK:   prdata = {24'd0, exit_mask_r};
      default:         prdata = '0;
    endcase
  end

  fss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd),
    .busy      (busy)
  );

  fss_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .dp_cmd      (dp_cmd),
    .dp_status   (dp_status),
    .in_data     (in_data),
    .base_weight (base_weight_r),
    .exit_mask   (exit_mask_r),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule
